/* hw/rtl/tsk_pkg.sv */
// types, constants and controller/datapath interface structs for the
// topological sort block; no dependencies
`timescale 1ns / 1ps

package tsk_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 256;

    localparam int VERTEX_W     = 6;
    localparam int FUNC_W       = 2;
    localparam int COUNT_W      = 7;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_TUSER_W  = 2;

    localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD_EDGE = 2'd0,
        FUNC_RUN      = 2'd1,
        FUNC_CLEAR    = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR_DEG,
        ST_COUNT_RD,
        ST_COUNT_CHK,
        ST_COUNT_INC,
        ST_INIT_RD,
        ST_INIT_CHK,
        ST_POP,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_DEC,
        ST_EMIT,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic accept;
        logic clr_deg;
        logic edge_rd;
        logic edge_next;
        logic deg_rd_tgt;
        logic deg_inc;
        logic vtx_rd;
        logic init_chk;
        logic pop;
        logic deg_dec;
        logic emit;
        logic emit_empty;
    } cmd_t;

    typedef struct packed {
        logic  in_valid;
        func_t func;
        logic  clr_done;
        logic  edge_done;
        logic  vtx_done;
        logic  edge_live;
        logic  edge_from_cur;
        logic  queue_empty;
        logic  none_emitted;
        logic  out_free;
    } status_t;

endpackage

/* hw/rtl/topological_sort_kahn.sv */
// top level of the kahn topological sort block
// depends on tsk_pkg, tsk_ctrl, tsk_datapath (and tsk_ram below it)
`timescale 1ns / 1ps

// Edges are loaded one transaction per cycle while idle (func 0) and appended
// to an edge store of MAX_EDGES entries, unless an end is not below the
// vertex count or the store is full; func 2 empties the store, func 3 is ignored.
// A run (func 1) first clears the in-degree table, one entry a cycle over all
// MAX_VERTICES entries, then walks the whole edge store to count in-degrees,
// checks every vertex below vertex_count (capped at MAX_VERTICES), and for
// every vertex popped from the ready queue walks the edge store again before
// emitting it. A run stalls while the result side holds off a waiting result.
// No new transaction is taken until the run ends. Results carry the vertex in
// tdata, tlast on the final one, tuser bit 0 = present and tuser bit 1 =
// incomplete (cycle detected) on the final one.

module topological_sort_kahn #(
    parameter int MAX_VERTICES = tsk_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = tsk_pkg::DEF_MAX_EDGES
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsk_pkg::COUNT_W-1:0]     cfg_wdata,  // vertex_count
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tsk_pkg::IN_TDATA_W-1:0]  s_tdata,    // src_vertex, dst_vertex
    input  logic [tsk_pkg::FUNC_W-1:0]      s_tuser,    // func
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tsk_pkg::OUT_TDATA_W-1:0] m_tdata,    // vertex
    output logic [tsk_pkg::OUT_TUSER_W-1:0] m_tuser,    // present, incomplete
    output logic                            m_tlast
);

    tsk_pkg::cmd_t    cmd;
    tsk_pkg::status_t status;

    tsk_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    tsk_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    assign s_tready = cmd.accept;

endmodule

/* hw/rtl/tsk_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module tsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/tsk_ctrl.sv */
// controller state machine for the topological sort block
// depends on tsk_pkg
`timescale 1ns / 1ps

module tsk_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  tsk_pkg::status_t status,
    output tsk_pkg::cmd_t    cmd
);

    tsk_pkg::state_t state_reg;
    tsk_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsk_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsk_pkg::ST_IDLE:
            begin
                if (status.in_valid && status.func == tsk_pkg::FUNC_RUN)
                begin
                    state_next = tsk_pkg::ST_CLR_DEG;
                end
            end
            tsk_pkg::ST_CLR_DEG:
            begin
                if (status.clr_done)
                begin
                    state_next = tsk_pkg::ST_COUNT_RD;
                end
            end
            tsk_pkg::ST_COUNT_RD:
            begin
                state_next = status.edge_done ? tsk_pkg::ST_INIT_RD : tsk_pkg::ST_COUNT_CHK;
            end
            tsk_pkg::ST_COUNT_CHK:
            begin
                state_next = status.edge_live ? tsk_pkg::ST_COUNT_INC : tsk_pkg::ST_COUNT_RD;
            end
            tsk_pkg::ST_COUNT_INC:
            begin
                state_next = tsk_pkg::ST_COUNT_RD;
            end
            tsk_pkg::ST_INIT_RD:
            begin
                state_next = status.vtx_done ? tsk_pkg::ST_POP : tsk_pkg::ST_INIT_CHK;
            end
            tsk_pkg::ST_INIT_CHK:
            begin
                state_next = tsk_pkg::ST_INIT_RD;
            end
            tsk_pkg::ST_POP:
            begin
                if (!status.queue_empty)
                begin
                    state_next = tsk_pkg::ST_SCAN_RD;
                end
                else if (status.none_emitted)
                begin
                    state_next = tsk_pkg::ST_EMPTY;
                end
                else
                begin
                    state_next = tsk_pkg::ST_IDLE;
                end
            end
            tsk_pkg::ST_SCAN_RD:
            begin
                state_next = status.edge_done ? tsk_pkg::ST_EMIT : tsk_pkg::ST_SCAN_CHK;
            end
            tsk_pkg::ST_SCAN_CHK:
            begin
                state_next = status.edge_from_cur ? tsk_pkg::ST_SCAN_DEC : tsk_pkg::ST_SCAN_RD;
            end
            tsk_pkg::ST_SCAN_DEC:
            begin
                state_next = tsk_pkg::ST_SCAN_RD;
            end
            tsk_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = tsk_pkg::ST_POP;
                end
            end
            tsk_pkg::ST_EMPTY:
            begin
                if (status.out_free)
                begin
                    state_next = tsk_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsk_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            tsk_pkg::ST_IDLE:      cmd.accept = 1'b1;
            tsk_pkg::ST_CLR_DEG:   cmd.clr_deg = 1'b1;
            tsk_pkg::ST_COUNT_RD:  cmd.edge_rd = 1'b1;
            tsk_pkg::ST_COUNT_CHK:
            begin
                cmd.deg_rd_tgt = status.edge_live;
                cmd.edge_next  = !status.edge_live;
            end
            tsk_pkg::ST_COUNT_INC:
            begin
                cmd.deg_inc   = 1'b1;
                cmd.edge_next = 1'b1;
            end
            tsk_pkg::ST_INIT_RD:   cmd.vtx_rd = 1'b1;
            tsk_pkg::ST_INIT_CHK:  cmd.init_chk = 1'b1;
            tsk_pkg::ST_POP:       cmd.pop = !status.queue_empty;
            tsk_pkg::ST_SCAN_RD:   cmd.edge_rd = 1'b1;
            tsk_pkg::ST_SCAN_CHK:
            begin
                cmd.deg_rd_tgt = status.edge_from_cur;
                cmd.edge_next  = !status.edge_from_cur;
            end
            tsk_pkg::ST_SCAN_DEC:
            begin
                cmd.deg_dec   = 1'b1;
                cmd.edge_next = 1'b1;
            end
            tsk_pkg::ST_EMIT:      cmd.emit = status.out_free;
            tsk_pkg::ST_EMPTY:     cmd.emit_empty = status.out_free;
            default:               cmd = '0;
        endcase
    end

endmodule

/* hw/rtl/tsk_datapath.sv */
// datapath: edge store, in-degree table, ready queue, counters, output register
// depends on tsk_pkg and tsk_ram
`timescale 1ns / 1ps

module tsk_datapath #(
    parameter int MAX_VERTICES = tsk_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = tsk_pkg::DEF_MAX_EDGES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tsk_pkg::cmd_t                     cmd,
    output tsk_pkg::status_t                  status,
    input  logic                              cfg_we,
    input  logic [tsk_pkg::COUNT_W-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    input  logic [tsk_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [tsk_pkg::FUNC_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsk_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic [tsk_pkg::OUT_TUSER_W-1:0]   m_tuser,
    output logic                              m_tlast
);

    localparam int VW   = tsk_pkg::VERTEX_W;
    localparam int CW   = tsk_pkg::COUNT_W;
    localparam int QAW  = $clog2(MAX_VERTICES);
    localparam int QCW  = $clog2(MAX_VERTICES + 1);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int ECW  = $clog2(MAX_EDGES + 1);
    localparam int DW   = $clog2(MAX_EDGES + 1);

    logic [CW-1:0]  vertex_count_reg;
    logic [ECW-1:0] edge_total_reg;
    logic [ECW-1:0] edge_idx_reg;
    logic [QCW-1:0] vtx_idx_reg;
    logic [QCW-1:0] head_reg;
    logic [QCW-1:0] tail_reg;
    logic [QCW-1:0] emitted_reg;

    logic              out_valid_reg;
    logic [VW-1:0]     out_vertex_reg;
    logic              out_present_reg;
    logic              out_last_reg;
    logic              out_incomplete_reg;

    logic [CW-1:0]     n_eff;
    tsk_pkg::func_t    func;
    logic [VW-1:0]     in_src;
    logic [VW-1:0]     in_dst;
    logic              in_take;
    logic              add_ok;

    logic [2*VW-1:0]   edge_rdata;
    logic [VW-1:0]     e_src;
    logic [VW-1:0]     e_dst;
    logic [DW-1:0]     deg_rdata;
    logic              deg_we;
    logic [QAW-1:0]    deg_waddr;
    logic [DW-1:0]     deg_wdata;
    logic              deg_re;
    logic [QAW-1:0]    deg_raddr;
    logic [VW-1:0]     cur;
    logic              push_init;
    logic              push_scan;
    logic              q_we;
    logic [VW-1:0]     q_wdata;
    logic              out_free;

    assign func    = tsk_pkg::func_t'(s_tuser);
    assign in_src  = s_tdata[VW-1:0];
    assign in_dst  = s_tdata[2*VW-1:VW];
    assign in_take = s_tvalid && cmd.accept;
    assign n_eff   = (vertex_count_reg > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                            : vertex_count_reg;
    assign add_ok  = in_take && func == tsk_pkg::FUNC_ADD_EDGE
                     && {1'b0, in_src} < n_eff && {1'b0, in_dst} < n_eff
                     && edge_total_reg != ECW'(MAX_EDGES);

    assign e_src = edge_rdata[VW-1:0];
    assign e_dst = edge_rdata[2*VW-1:VW];

    tsk_ram #(
        .WIDTH (2 * VW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (add_ok),
        .waddr (edge_total_reg[EAW-1:0]),
        .wdata ({in_dst, in_src}),
        .re    (cmd.edge_rd),
        .raddr (edge_idx_reg[EAW-1:0]),
        .rdata (edge_rdata)
    );

    // in-degree table
    assign deg_we    = cmd.clr_deg || cmd.deg_inc || (cmd.deg_dec && deg_rdata != '0);
    assign deg_waddr = cmd.clr_deg ? vtx_idx_reg[QAW-1:0] : e_dst[QAW-1:0];
    always_comb
    begin
        if (cmd.clr_deg)
        begin
            deg_wdata = '0;
        end
        else if (cmd.deg_inc)
        begin
            deg_wdata = deg_rdata + DW'(1);
        end
        else
        begin
            deg_wdata = deg_rdata - DW'(1);
        end
    end
    assign deg_re    = cmd.deg_rd_tgt || cmd.vtx_rd;
    assign deg_raddr = cmd.vtx_rd ? vtx_idx_reg[QAW-1:0] : e_dst[QAW-1:0];

    tsk_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_VERTICES)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .re    (deg_re),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

    // ready queue
    assign push_init = cmd.init_chk && deg_rdata == '0;
    assign push_scan = cmd.deg_dec && deg_rdata == DW'(1);
    assign q_we      = (push_init || push_scan) && tail_reg != QCW'(MAX_VERTICES);
    assign q_wdata   = push_init ? VW'(vtx_idx_reg) : e_dst;

    tsk_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (tail_reg[QAW-1:0]),
        .wdata (q_wdata),
        .re    (cmd.pop),
        .raddr (head_reg[QAW-1:0]),
        .rdata (cur)
    );

    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= tsk_pkg::VERTEX_COUNT_RESET;
            edge_total_reg   <= '0;
            edge_idx_reg     <= '0;
            vtx_idx_reg      <= '0;
            head_reg         <= '0;
            tail_reg         <= '0;
            emitted_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
            if (add_ok)
            begin
                edge_total_reg <= edge_total_reg + ECW'(1);
            end
            if (in_take && func == tsk_pkg::FUNC_CLEAR)
            begin
                edge_total_reg <= '0;
            end
            if (in_take && func == tsk_pkg::FUNC_RUN)
            begin
                edge_idx_reg <= '0;
                vtx_idx_reg  <= '0;
                head_reg     <= '0;
                tail_reg     <= '0;
                emitted_reg  <= '0;
            end
            if (cmd.clr_deg)
            begin
                vtx_idx_reg <= status.clr_done ? '0 : vtx_idx_reg + QCW'(1);
            end
            if (cmd.init_chk)
            begin
                vtx_idx_reg <= vtx_idx_reg + QCW'(1);
            end
            if (cmd.edge_next)
            begin
                edge_idx_reg <= edge_idx_reg + ECW'(1);
            end
            if (q_we)
            begin
                tail_reg <= tail_reg + QCW'(1);
            end
            if (cmd.pop)
            begin
                head_reg     <= head_reg + QCW'(1);
                edge_idx_reg <= '0;
            end
            if (cmd.emit)
            begin
                emitted_reg <= emitted_reg + QCW'(1);
            end
            if (cmd.emit || cmd.emit_empty)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_vertex_reg     <= cur;
            out_present_reg    <= 1'b1;
            out_last_reg       <= head_reg == tail_reg;
            out_incomplete_reg <= head_reg == tail_reg
                                  && (CW'(emitted_reg) + CW'(1)) < n_eff;
        end
        else if (cmd.emit_empty)
        begin
            out_vertex_reg     <= '0;
            out_present_reg    <= 1'b0;
            out_last_reg       <= 1'b1;
            out_incomplete_reg <= n_eff != '0;
        end
    end

    assign status.in_valid      = s_tvalid;
    assign status.func          = func;
    assign status.clr_done      = vtx_idx_reg == QCW'(MAX_VERTICES - 1);
    assign status.edge_done     = edge_idx_reg == edge_total_reg;
    assign status.vtx_done      = CW'(vtx_idx_reg) == n_eff;
    assign status.edge_live     = {1'b0, e_src} < n_eff && {1'b0, e_dst} < n_eff;
    assign status.edge_from_cur = e_src == cur && {1'b0, e_dst} < n_eff;
    assign status.queue_empty   = head_reg == tail_reg;
    assign status.none_emitted  = emitted_reg == '0;
    assign status.out_free      = out_free;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tsk_pkg::OUT_TDATA_W - VW){1'b0}}, out_vertex_reg};
    assign m_tuser  = {out_incomplete_reg, out_present_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* bench/testbench.sv */
// self-checking bench for topological_sort_kahn: streams edge, run and clear
// transactions, predicts every emitted vertex in-bench and checks each result
// depends on tsk_pkg and the topological_sort_kahn rtl
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_V        = tsk_pkg::DEF_MAX_VERTICES;
    localparam int MAX_E        = tsk_pkg::DEF_MAX_EDGES;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 10000000;
    localparam int HOLD_CYCLES  = 700;

    typedef struct {
        logic [tsk_pkg::VERTEX_W-1:0] vertex;
        logic                         present;
        logic                         last;
        logic                         incomplete;
    } sorted_vertex_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [tsk_pkg::COUNT_W-1:0]     cfg_wdata;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [tsk_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic [tsk_pkg::FUNC_W-1:0]      s_tuser;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [tsk_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [tsk_pkg::OUT_TUSER_W-1:0] m_tuser;
    logic                            m_tlast;

    // bench copy of the block state
    logic [tsk_pkg::VERTEX_W-1:0] edge_src_m [MAX_E];
    logic [tsk_pkg::VERTEX_W-1:0] edge_dst_m [MAX_E];
    int                           edge_total_m;
    logic [tsk_pkg::COUNT_W-1:0]  vcount_m;

    sorted_vertex_t order_q [$];

    int  err_count;
    int  cycle_count;
    int  items_sent;
    int  runs_sent;
    int  vertices_checked;
    int  cfg_writes;
    int  tx_gap_max;
    int  rx_gap_max;
    int  rx_hold;
    int  rx_gap;
    bit  rx_took;

    topological_sort_kahn DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("topological_sort_kahn: mismatch");
            $finish;
        end
    end

    // bench model of each transaction; on a run, the kahn order of the stored edges is appended to order_q
    function automatic void kahn_predict(tsk_pkg::func_t f,
                                         logic [tsk_pkg::VERTEX_W-1:0] src,
                                         logic [tsk_pkg::VERTEX_W-1:0] dst);
        int             n;
        int             e;
        int             v;
        int             head;
        int             tail;
        int             cur;
        int             t;
        int             deg [MAX_V];
        int             ready [MAX_V];
        sorted_vertex_t r;
        sorted_vertex_t run_q [$];
        n = (vcount_m > MAX_V) ? MAX_V : int'(vcount_m);
        case (f)
            tsk_pkg::FUNC_ADD_EDGE:
            begin
                if (src < n && dst < n && edge_total_m < MAX_E)
                begin
                    edge_src_m[edge_total_m] = src;
                    edge_dst_m[edge_total_m] = dst;
                    edge_total_m++;
                end
            end
            tsk_pkg::FUNC_RUN:
            begin
                for (v = 0; v < MAX_V; v++)
                    deg[v] = 0;
                for (e = 0; e < edge_total_m; e++)
                    if (edge_src_m[e] < n && edge_dst_m[e] < n)
                        deg[edge_dst_m[e]]++;
                head = 0;
                tail = 0;
                for (v = 0; v < n; v++)
                    if (deg[v] == 0)
                    begin
                        ready[tail] = v;
                        tail++;
                    end
                while (head < tail)
                begin
                    cur = ready[head];
                    head++;
                    for (e = 0; e < edge_total_m; e++)
                    begin
                        t = edge_dst_m[e];
                        if (edge_src_m[e] == cur && t < n && deg[t] > 0)
                        begin
                            deg[t]--;
                            if (deg[t] == 0 && tail < MAX_V)
                            begin
                                ready[tail] = t;
                                tail++;
                            end
                        end
                    end
                    r.vertex     = cur[tsk_pkg::VERTEX_W-1:0];
                    r.present    = 1'b1;
                    r.last       = 1'b0;
                    r.incomplete = 1'b0;
                    run_q = {run_q, r};
                end
                if (run_q.size() == 0)
                begin
                    r.vertex     = '0;
                    r.present    = 1'b0;
                    r.last       = 1'b1;
                    r.incomplete = (n > 0);
                    run_q = {run_q, r};
                end
                else
                begin
                    run_q[run_q.size()-1].last       = 1'b1;
                    run_q[run_q.size()-1].incomplete = (run_q.size() < n);
                end
                foreach (run_q[i])
                    order_q = {order_q, run_q[i]};
            end
            tsk_pkg::FUNC_CLEAR:
                edge_total_m = 0;
            default:
                ;
        endcase
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_results
        sorted_vertex_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_took = 1'b1;
            if (order_q.size() == 0)
            begin
                $error("unexpected result transaction: vertex %0d", m_tdata);
                err_count++;
            end
            else
            begin
                want = order_q.pop_front();
                vertices_checked++;
                if (m_tdata !== {{(tsk_pkg::OUT_TDATA_W-tsk_pkg::VERTEX_W){1'b0}},
                                 want.vertex})
                begin
                    $error("vertex: expected %0d, got %0d", want.vertex, m_tdata);
                    err_count++;
                end
                if (m_tuser[0] !== want.present)
                begin
                    $error("present: expected %0d, got %0d", want.present, m_tuser[0]);
                    err_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    err_count++;
                end
                if (m_tuser[1] !== want.incomplete)
                begin
                    $error("incomplete: expected %0d, got %0d", want.incomplete,
                           m_tuser[1]);
                    err_count++;
                end
            end
        end
    end

    // result-side ready with per-transaction gaps and long hold-offs
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_tready <= 1'b0;
                rx_hold--;
            end
            else
            begin
                if (rx_took)
                begin
                    rx_gap  = $urandom_range(0, rx_gap_max);
                    rx_took = 1'b0;
                end
                if (rx_gap > 0)
                begin
                    m_tready <= 1'b0;
                    rx_gap--;
                end
                else
                    m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(tsk_pkg::func_t f, logic [tsk_pkg::VERTEX_W-1:0] src,
                             logic [tsk_pkg::VERTEX_W-1:0] dst);
        int g;
        int i;
        g = $urandom_range(0, tx_gap_max);
        for (i = 0; i < g; i++)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(tsk_pkg::IN_TDATA_W-2*tsk_pkg::VERTEX_W){1'b0}}, dst, src};
        s_tuser  <= f;
        do
            @(posedge clk);
        while (!s_tready);
        kahn_predict(f, src, dst);
        if (f != tsk_pkg::FUNC_NONE)
            items_sent++;
        if (f == tsk_pkg::FUNC_RUN)
            runs_sent++;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (order_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_count(logic [tsk_pkg::COUNT_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        vcount_m  = v;
        cfg_writes++;
    endtask

    task automatic pick_gaps();
        int k;
        k = $urandom_range(0, 3);
        tx_gap_max = (k == 0) ? 0 : (k == 1) ? 16 : $urandom_range(0, 16);
        k = $urandom_range(0, 3);
        rx_gap_max = (k == 0) ? 0 : (k == 1) ? 16 : $urandom_range(0, 16);
    endtask

    task automatic test_empty_store();
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
    endtask

    task automatic test_small_dag();
        set_count(7'd6);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd0, 6'd1);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd0, 6'd2);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd2, 6'd1);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd1, 6'd3);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd3, 6'd5);
        // out-of-range ends are dropped
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd6, 6'd0);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd2, 6'd63);
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
    endtask

    task automatic test_field_extremes();
        set_count(7'd64);
        send_item(tsk_pkg::FUNC_CLEAR, 6'd63, 6'd63);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd63, 6'd63);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd0, 6'd63);
        send_item(tsk_pkg::FUNC_NONE, 6'd63, 6'd63);
        send_item(tsk_pkg::FUNC_RUN, 6'd63, 6'd63);
    endtask

    task automatic test_cycles();
        set_count(7'd2);
        send_item(tsk_pkg::FUNC_CLEAR, 6'd0, 6'd0);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd0, 6'd1);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd1, 6'd0);
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
    endtask

    task automatic test_count_range();
        set_count(7'd64);
        send_item(tsk_pkg::FUNC_CLEAR, 6'd0, 6'd0);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd40, 6'd3);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd3, 6'd2);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd1, 6'd0);
        // stored edge from vertex 40 falls outside the lowered count
        set_count(7'd5);
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
        set_count(7'd0);
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
        set_count(7'd127);
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
    endtask

    task automatic test_store_full();
        int i;
        int a;
        int b;
        pick_gaps();
        set_count(7'd4);
        send_item(tsk_pkg::FUNC_CLEAR, 6'd0, 6'd0);
        for (i = 0; i < MAX_E + 2; i++)
        begin
            a = $urandom_range(0, 2);
            b = $urandom_range(a + 1, 3);
            send_item(tsk_pkg::FUNC_ADD_EDGE, a[tsk_pkg::VERTEX_W-1:0],
                      b[tsk_pkg::VERTEX_W-1:0]);
        end
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
        send_item(tsk_pkg::FUNC_ADD_EDGE, 6'd3, 6'd0);
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
    endtask

    task automatic test_output_backpressure();
        int i;
        tx_gap_max = 0;
        set_count(7'd64);
        send_item(tsk_pkg::FUNC_CLEAR, 6'd0, 6'd0);
        rx_hold = HOLD_CYCLES;
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
        for (i = 0; i < 5; i++)
            send_item(tsk_pkg::FUNC_ADD_EDGE, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
        send_item(tsk_pkg::FUNC_RUN, 6'd0, 6'd0);
    endtask

    task automatic test_random_graphs(int budget);
        int          done;
        int          round;
        int          n;
        int          ne;
        int          i;
        int          j;
        int          k;
        int          a;
        int          b;
        int          tmp;
        int          perm [MAX_V];
        logic [6:0]  c;
        done  = 0;
        round = 0;
        while (done < budget)
        begin
            if (round % 3 == 0)
            begin
                k = $urandom_range(0, 7);
                case (k)
                    0:       c = 7'd0;
                    1:       c = 7'd1;
                    2:       c = 7'd64;
                    3:       c = 7'd127;
                    4:       c = 7'($urandom_range(65, 127));
                    default: c = 7'($urandom_range(2, 24));
                endcase
                set_count(c);
            end
            pick_gaps();
            n = (vcount_m > MAX_V) ? MAX_V : int'(vcount_m);
            for (i = 0; i < MAX_V; i++)
                perm[i] = i;
            for (i = n - 1; i > 0; i--)
            begin
                j       = $urandom_range(0, i);
                tmp     = perm[i];
                perm[i] = perm[j];
                perm[j] = tmp;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                send_item(tsk_pkg::FUNC_CLEAR, 6'($urandom_range(0, 63)),
                          6'($urandom_range(0, 63)));
                done++;
            end
            ne = $urandom_range(0, 20);
            for (i = 0; i < ne; i++)
            begin
                k = $urandom_range(0, 9);
                if (k < 7 && n >= 2)
                begin
                    a = $urandom_range(0, n - 2);
                    b = $urandom_range(a + 1, n - 1);
                    send_item(tsk_pkg::FUNC_ADD_EDGE, 6'(perm[a]), 6'(perm[b]));
                    done++;
                end
                else if (k < 9)
                begin
                    send_item(tsk_pkg::FUNC_ADD_EDGE, 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)));
                    done++;
                end
                else
                    send_item(tsk_pkg::FUNC_NONE, 6'($urandom_range(0, 63)),
                              6'($urandom_range(0, 63)));
            end
            send_item(tsk_pkg::FUNC_RUN, 6'($urandom_range(0, 63)),
                      6'($urandom_range(0, 63)));
            done++;
            round++;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        err_count    = 0;
        cycle_count  = 0;
        items_sent   = 0;
        runs_sent    = 0;
        vertices_checked = 0;
        cfg_writes   = 0;
        tx_gap_max   = 4;
        rx_gap_max   = 4;
        rx_hold      = 0;
        rx_gap       = 0;
        rx_took      = 1'b0;
        vcount_m     = tsk_pkg::VERTEX_COUNT_RESET;
        edge_total_m = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_small_dag();
        test_field_extremes();
        test_cycles();
        test_count_range();
        test_output_backpressure();
        test_store_full();
        test_random_graphs(76);

        wait_idle();
        $display("sent %0d transactions including %0d sort runs, checked %0d vertices",
                 items_sent, runs_sent, vertices_checked);
        $display("%0d vertex count writes, one output hold-off of %0d cycles",
                 cfg_writes, HOLD_CYCLES);
        if (err_count == 0 && order_q.size() == 0)
            $display("topological_sort_kahn: match");
        else
            $display("topological_sort_kahn: mismatch");
        $finish;
    end

endmodule
